>>> rtl/disk_image_sector_chain_writer_top_defines.svh
// assertion macros for the sector chain writer
// used by the top level only, expects clk and rst_n in scope
`ifndef DISK_IMAGE_SECTOR_CHAIN_WRITER_TOP_DEFINES_SVH
`define DISK_IMAGE_SECTOR_CHAIN_WRITER_TOP_DEFINES_SVH

// condition must never hold outside reset
`define DSCW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define DSCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dscw_pkg.sv
// shared constants, types and table functions of the sector chain writer
// no dependencies; imported by every module of the block except dscw_ram
`default_nettype none

package dscw_pkg;

  // geometry
  localparam int SECTOR_BYTES = 256;
  localparam int PAGE_COUNT   = 802;
  localparam int IMAGE_BYTES  = PAGE_COUNT * SECTOR_BYTES;
  localparam int IMG_AW       = 18;
  localparam int PAGE_W       = 10;
  localparam int TRK_W        = 6;
  localparam int SEC_W        = 5;
  localparam int MAX_TRACKS   = 42;
  localparam int MAP_TRACK    = 18;
  localparam logic [PAGE_W-1:0] MAP_PAGE = 10'd357;

  // fill byte codes
  localparam logic [7:0] FILL_FULL  = 8'hFF;
  localparam logic [7:0] FILL_FIRST = 8'h02;
  localparam logic [7:0] FILL_EMPTY = 8'h00;

  // request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // config port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_NUM_TRACKS = 1'b0;
  localparam logic REG_SKIP_DIR   = 1'b1;

  typedef struct packed {
    logic [TRK_W-1:0] num_tracks;
    logic             skip_dir;
  } cfg_regs_t;

  typedef struct packed {
    logic             ok;
    logic [TRK_W-1:0] trk;
    logic [SEC_W-1:0] sec;
  } nav_res_t;

  // sectors per track, zero outside 1..42
  function automatic logic [SEC_W-1:0] trk_sectors(input logic [TRK_W-1:0] t);
    logic [SEC_W-1:0] n;
    if (t == 6'd0 || t > 6'(MAX_TRACKS)) n = 5'd0;
    else if (t < 6'd18) n = 5'd21;
    else if (t < 6'd25) n = 5'd19;
    else if (t < 6'd31) n = 5'd18;
    else n = 5'd17;
    return n;
  endfunction

  // first sector page of each track
  function automatic logic [PAGE_W-1:0] trk_first(input logic [TRK_W-1:0] t);
    logic [PAGE_W-1:0] p;
    case (t)
      6'd1:  p = 10'd0;    6'd2:  p = 10'd21;   6'd3:  p = 10'd42;   6'd4:  p = 10'd63;
      6'd5:  p = 10'd84;   6'd6:  p = 10'd105;  6'd7:  p = 10'd126;  6'd8:  p = 10'd147;
      6'd9:  p = 10'd168;  6'd10: p = 10'd189;  6'd11: p = 10'd210;  6'd12: p = 10'd231;
      6'd13: p = 10'd252;  6'd14: p = 10'd273;  6'd15: p = 10'd294;  6'd16: p = 10'd315;
      6'd17: p = 10'd336;  6'd18: p = 10'd357;  6'd19: p = 10'd376;  6'd20: p = 10'd395;
      6'd21: p = 10'd414;  6'd22: p = 10'd433;  6'd23: p = 10'd452;  6'd24: p = 10'd471;
      6'd25: p = 10'd490;  6'd26: p = 10'd508;  6'd27: p = 10'd526;  6'd28: p = 10'd544;
      6'd29: p = 10'd562;  6'd30: p = 10'd580;  6'd31: p = 10'd598;  6'd32: p = 10'd615;
      6'd33: p = 10'd632;  6'd34: p = 10'd649;  6'd35: p = 10'd666;  6'd36: p = 10'd683;
      6'd37: p = 10'd700;  6'd38: p = 10'd717;  6'd39: p = 10'd734;  6'd40: p = 10'd751;
      6'd41: p = 10'd768;  6'd42: p = 10'd785;
      default: p = 10'd0;
    endcase
    return p;
  endfunction

  // page of a sector, out-of-range track or sector folds to the first one
  function automatic logic [PAGE_W-1:0] sec_page(input logic [TRK_W-1:0] trk,
                                                 input logic [SEC_W-1:0] sec);
    logic [TRK_W-1:0] tt;
    logic [SEC_W-1:0] ss;
    tt = (trk == 6'd0 || trk > 6'(MAX_TRACKS)) ? 6'd1 : trk;
    ss = (sec >= trk_sectors(tt)) ? 5'd0 : sec;
    return trk_first(tt) + {5'd0, ss};
  endfunction

  // interleave tables per speed zone
  function automatic logic [SEC_W-1:0] ilv_z3(input logic [SEC_W-1:0] i);
    return (i < 5'd11) ? 5'(i + 5'd10) : 5'(i - 5'd11);
  endfunction

  function automatic logic [SEC_W-1:0] ilv_z2(input logic [SEC_W-1:0] i);
    return (i < 5'd9) ? 5'(i + 5'd10) : 5'(i - 5'd9);
  endfunction

  function automatic logic [SEC_W-1:0] ilv_t18(input logic [SEC_W-1:0] i);
    return (i < 5'd16) ? 5'(i + 5'd3) : 5'(i - 5'd16);
  endfunction

  function automatic logic [SEC_W-1:0] ilv_z1(input logic [SEC_W-1:0] i);
    logic [SEC_W-1:0] r;
    if (i < 5'd8) r = 5'(i + 5'd10);
    else if (i == 5'd8) r = 5'd1;
    else if (i == 5'd9) r = 5'd0;
    else r = 5'(i - 5'd8);
    return r;
  endfunction

  function automatic logic [SEC_W-1:0] ilv_z0(input logic [SEC_W-1:0] i);
    return (i < 5'd7) ? 5'(i + 5'd10) : 5'(i - 5'd7);
  endfunction

  // reset content of one image byte: zero except the blank allocation map
  function automatic logic [7:0] init_byte(input logic [IMG_AW-1:0] a);
    logic [7:0]       off;
    logic [TRK_W-1:0] k;
    logic [SEC_W-1:0] n;
    logic [7:0]       v;
    off = a[7:0];
    k   = off[7:2];
    n   = trk_sectors(k);
    v   = 8'h00;
    if (a[IMG_AW-1:8] == MAP_PAGE && off >= 8'd4 && off <= 8'd143
        && k != 6'(MAP_TRACK)) begin
      case (off[1:0])
        2'd0: v = {3'd0, n};
        2'd1: v = 8'hFF;
        2'd2: v = 8'hFF;
        default: v = (n == 5'd21) ? 8'h1F : (n == 5'd19) ? 8'h07 :
                     (n == 5'd18) ? 8'h03 : 8'h01;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dscw_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module dscw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dscw_cfg.sv
// configuration registers behind the apb-style port
// depends on dscw_pkg
`default_nettype none

module dscw_cfg import dscw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_regs_t              cfg
);

  logic [TRK_W-1:0] num_tracks_r, num_tracks_nxt;
  logic             skip_dir_r, skip_dir_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes, decoded on the word address bit
  always_comb begin
    num_tracks_nxt = num_tracks_r;
    skip_dir_nxt   = skip_dir_r;
    if (wr_en) begin
      case (paddr[2])
        REG_NUM_TRACKS: num_tracks_nxt = pwdata[TRK_W-1:0];
        REG_SKIP_DIR:   skip_dir_nxt   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tracks_r <= 6'd35;
      skip_dir_r   <= 1'b1;
    end else begin
      num_tracks_r <= num_tracks_nxt;
      skip_dir_r   <= skip_dir_nxt;
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      REG_NUM_TRACKS: prdata = {{(CFG_DW-TRK_W){1'b0}}, num_tracks_r};
      REG_SKIP_DIR:   prdata = {{(CFG_DW-1){1'b0}}, skip_dir_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.num_tracks = num_tracks_r;
  assign cfg.skip_dir   = skip_dir_r;

endmodule

`default_nettype wire

>>> rtl/dscw_nav.sv
// next-sector selection: interleave by speed zone, track step, disk-full check
// depends on dscw_pkg
`default_nettype none

module dscw_nav import dscw_pkg::*; (
  input  wire logic [TRK_W-1:0] trk,
  input  wire logic [SEC_W-1:0] sec,
  input  wire cfg_regs_t        cfg,
  output nav_res_t              nav
);

  logic [TRK_W-1:0] last_trk;
  logic [SEC_W-1:0] nsec;

  // tracks in use, clamped to the largest geometry
  assign last_trk = (cfg.num_tracks > 6'(MAX_TRACKS)) ? 6'(MAX_TRACKS) : cfg.num_tracks;

  // interleave step, index folded into the zone's sector count
  always_comb begin
    if (trk < 6'd18)
      nsec = ilv_z3((sec >= 5'd21) ? 5'(sec - 5'd21) : sec);
    else if (trk == 6'(MAP_TRACK))
      nsec = ilv_t18((sec >= 5'd19) ? 5'(sec - 5'd19) : sec);
    else if (trk < 6'd25)
      nsec = ilv_z2((sec >= 5'd19) ? 5'(sec - 5'd19) : sec);
    else if (trk < 6'd31)
      nsec = ilv_z1((sec >= 5'd18) ? 5'(sec - 5'd18) : sec);
    else
      nsec = ilv_z0((sec >= 5'd17) ? 5'(sec - 5'd17) : sec);
  end

  // wrap to sector zero moves to the next track, maybe over the directory track
  always_comb begin
    nav.ok  = 1'b1;
    nav.sec = nsec;
    nav.trk = trk;
    if (nsec == 5'd0) begin
      if (trk >= last_trk) begin
        nav.ok = 1'b0;
      end else if (trk == 6'd17 && cfg.skip_dir) begin
        nav.trk = 6'd19;
      end else begin
        nav.trk = 6'(trk + 6'd1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dscw_seq.sv
// request sequencer: input buffer, image memory read-modify-write steps,
// clearing sweep after reset and result register
// depends on dscw_pkg
`default_nettype none

module dscw_seq import dscw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic [IMG_AW-1:0] in_read_address,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_status,
  output logic [TRK_W-1:0]       out_cur_track,
  output logic [SEC_W-1:0]       out_cur_sector,
  output logic [7:0]             out_fill_position,
  output logic [7:0]             out_read_data,
  // next-sector unit
  output logic [TRK_W-1:0]       cur_trk,
  output logic [SEC_W-1:0]       cur_sec,
  input  wire nav_res_t          nav,
  // image memory
  output logic                   ram_we,
  output logic [IMG_AW-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata,
  output logic                   ram_re,
  output logic [IMG_AW-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LINK  = 7'b0000100,
    ST_NEW   = 7'b0001000,
    ST_MAPC  = 7'b0010000,
    ST_MAPW  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } seq_state_t;

  // control state
  seq_state_t        state_r, state_nxt;
  logic [IMG_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic              buf_valid_r, buf_valid_nxt;
  logic [TRK_W-1:0]  trk_r, trk_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic [7:0]        fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload and per-request flags
  logic [1:0]        buf_mode_r, buf_mode_nxt;
  logic [7:0]        buf_byte_r, buf_byte_nxt;
  logic [IMG_AW-1:0] buf_addr_r, buf_addr_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [PAGE_W-1:0] lnk_page_r, lnk_page_nxt;
  logic              bset_r, bset_nxt;
  logic              status_r, status_nxt;
  logic              rd_sel_r, rd_sel_nxt;
  logic              fin_fill_r, fin_fill_nxt;
  logic              fin_wr_r, fin_wr_nxt;
  logic              out_status_r, out_status_nxt;
  logic [TRK_W-1:0]  out_trk_r, out_trk_nxt;
  logic [SEC_W-1:0]  out_sec_r, out_sec_nxt;
  logic [7:0]        out_fill_r, out_fill_nxt;
  logic [7:0]        out_rd_r, out_rd_nxt;

  // helpers
  logic [PAGE_W-1:0] cur_page;
  logic [7:0]        cnt_off, bm_off, bm_bit, fill_inc;
  logic              accept, out_free, bset;

  assign cur_page = sec_page(trk_r, sec_r);
  assign cnt_off  = {trk_r, 2'b00};
  assign bm_off   = 8'(cnt_off + 8'd1 + {6'd0, sec_r[4:3]});
  assign bm_bit   = 8'd1 << sec_r[2:0];
  assign fill_inc = 8'(fill_r + 8'd1);
  assign bset     = |(ram_rdata & bm_bit);

  assign in_stall = buf_valid_r || (state_r == ST_CLEAR);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign cur_trk = trk_r;
  assign cur_sec = sec_r;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    buf_valid_nxt  = buf_valid_r;
    trk_nxt        = trk_r;
    sec_nxt        = sec_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r;
    buf_mode_nxt   = buf_mode_r;
    buf_byte_nxt   = buf_byte_r;
    buf_addr_nxt   = buf_addr_r;
    byte_nxt       = byte_r;
    lnk_page_nxt   = lnk_page_r;
    bset_nxt       = bset_r;
    status_nxt     = status_r;
    rd_sel_nxt     = rd_sel_r;
    fin_fill_nxt   = fin_fill_r;
    fin_wr_nxt     = fin_wr_r;
    out_status_nxt = out_status_r;
    out_trk_nxt    = out_trk_r;
    out_sec_nxt    = out_sec_r;
    out_fill_nxt   = out_fill_r;
    out_rd_nxt     = out_rd_r;
    ram_we         = 1'b0;
    ram_waddr      = {cur_page, 8'd1};
    ram_wdata      = fill_r;
    ram_re         = 1'b0;
    ram_raddr      = {MAP_PAGE, bm_off};

    // input buffer
    if (accept) begin
      buf_valid_nxt = 1'b1;
      buf_mode_nxt  = in_mode;
      buf_byte_nxt  = in_data_byte;
      buf_addr_nxt  = in_read_address;
    end

    // result taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // write the reset image one byte a cycle
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = init_byte(clr_addr_r);
        if (clr_addr_r == 18'(IMAGE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = 18'(clr_addr_r + 18'd1);
        end
      end

      // dispatch the buffered request
      ST_IDLE: begin
        if (buf_valid_r) begin
          buf_valid_nxt = 1'b0;
          byte_nxt      = buf_byte_r;
          status_nxt    = 1'b0;
          rd_sel_nxt    = 1'b0;
          fin_fill_nxt  = 1'b0;
          fin_wr_nxt    = 1'b0;
          state_nxt     = ST_FIN;
          case (buf_mode_r)
            MODE_WRITE: begin
              if (fill_r == FILL_FULL) begin
                if (!nav.ok) begin
                  status_nxt = 1'b1;
                end else begin
                  // link byte: next track into the full sector
                  ram_we       = 1'b1;
                  ram_waddr    = {cur_page, 8'd0};
                  ram_wdata    = {2'b00, nav.trk};
                  lnk_page_nxt = cur_page;
                  trk_nxt      = nav.trk;
                  sec_nxt      = nav.sec;
                  state_nxt    = ST_LINK;
                end
              end else if (fill_r == FILL_EMPTY) begin
                // first byte of a fresh sector, start the map update
                ram_re    = 1'b1;
                ram_raddr = {MAP_PAGE, bm_off};
                ram_we    = 1'b1;
                ram_waddr = {cur_page, 8'd2};
                ram_wdata = buf_byte_r;
                fill_nxt  = FILL_FIRST;
                state_nxt = ST_MAPC;
              end else begin
                // append after the last used position
                ram_we     = 1'b1;
                ram_waddr  = {cur_page, fill_inc};
                ram_wdata  = buf_byte_r;
                fill_nxt   = fill_inc;
                fin_wr_nxt = 1'b1;
              end
            end
            MODE_CLOSE: begin
              if (nav.ok) begin
                trk_nxt      = nav.trk;
                sec_nxt      = nav.sec;
                ram_re       = 1'b1;
                ram_raddr    = {sec_page(nav.trk, nav.sec), 8'd1};
                fin_fill_nxt = 1'b1;
              end else begin
                status_nxt = 1'b1;
              end
            end
            MODE_READ: begin
              if (buf_addr_r[IMG_AW-1:8] < 10'(PAGE_COUNT)) begin
                ram_re     = 1'b1;
                ram_raddr  = buf_addr_r;
                rd_sel_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // link byte: next sector into the full sector
      ST_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = {lnk_page_r, 8'd1};
        ram_wdata = {3'd0, sec_r};
        state_nxt = ST_NEW;
      end

      // first byte of the newly linked sector, start the map update
      ST_NEW: begin
        ram_re    = 1'b1;
        ram_raddr = {MAP_PAGE, bm_off};
        ram_we    = 1'b1;
        ram_waddr = {cur_page, 8'd2};
        ram_wdata = byte_r;
        fill_nxt  = FILL_FIRST;
        state_nxt = ST_MAPC;
      end

      // bitmap byte arrives: clear the sector's free bit, fetch the count
      ST_MAPC: begin
        bset_nxt = bset;
        if (bset) begin
          ram_we    = 1'b1;
          ram_waddr = {MAP_PAGE, bm_off};
          ram_wdata = ram_rdata & ~bm_bit;
        end
        ram_re    = 1'b1;
        ram_raddr = {MAP_PAGE, cnt_off};
        state_nxt = ST_MAPW;
      end

      // free count arrives: lower it if the free bit was set, unless already empty
      ST_MAPW: begin
        if (bset_r && ram_rdata != 8'd0) begin
          ram_we    = 1'b1;
          ram_waddr = {MAP_PAGE, cnt_off};
          ram_wdata = 8'(ram_rdata - 8'd1);
        end
        fin_wr_nxt = 1'b1;
        state_nxt  = ST_FIN;
      end

      // fill byte write-back and result load, held while the output is busy
      ST_FIN: begin
        if (fin_wr_r) begin
          ram_we    = 1'b1;
          ram_waddr = {cur_page, 8'd1};
          ram_wdata = fill_r;
        end
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_trk_nxt    = trk_r;
          out_sec_nxt    = sec_r;
          out_fill_nxt   = fin_fill_r ? ram_rdata : fill_r;
          out_rd_nxt     = rd_sel_r ? ram_rdata : 8'd0;
          if (fin_fill_r) begin
            fill_nxt = ram_rdata;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      buf_valid_r <= 1'b0;
      trk_r       <= 6'd1;
      sec_r       <= 5'd0;
      fill_r      <= FILL_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      buf_valid_r <= buf_valid_nxt;
      trk_r       <= trk_nxt;
      sec_r       <= sec_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    buf_mode_r   <= buf_mode_nxt;
    buf_byte_r   <= buf_byte_nxt;
    buf_addr_r   <= buf_addr_nxt;
    byte_r       <= byte_nxt;
    lnk_page_r   <= lnk_page_nxt;
    bset_r       <= bset_nxt;
    status_r     <= status_nxt;
    rd_sel_r     <= rd_sel_nxt;
    fin_fill_r   <= fin_fill_nxt;
    fin_wr_r     <= fin_wr_nxt;
    out_status_r <= out_status_nxt;
    out_trk_r    <= out_trk_nxt;
    out_sec_r    <= out_sec_nxt;
    out_fill_r   <= out_fill_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_cur_track     = out_trk_r;
  assign out_cur_sector    = out_sec_r;
  assign out_fill_position = out_fill_r;
  assign out_read_data     = out_rd_r;

endmodule

`default_nettype wire

>>> rtl/disk_image_sector_chain_writer_top.sv
// Sector chain writer for a disk image of up to 42 tracks in one 205312-byte memory
// with one write and one registered read port. After reset the block runs a clearing
// pass that writes zeros and the blank allocation map, and stalls requests meanwhile;
// configuration writes are taken at any time. Each request gives one result. A read,
// a close, or a byte appended to a partly filled sector goes from IDLE straight to FIN;
// the first byte of a fresh sector passes MAPC and MAPW in between (free bit and free
// count are read, modified and written back in the allocation map); a byte that fills
// past a full sector passes LINK and NEW before those (two link bytes first). The steps
// follow from the single write port of the image memory. One request waits in an input
// buffer while the previous one is worked on, and a result waits in the output register.
// depends on dscw_pkg, dscw_cfg, dscw_nav, dscw_seq, dscw_ram and the defines header
`default_nettype none

`include "disk_image_sector_chain_writer_top_defines.svh"

module disk_image_sector_chain_writer_top import dscw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic [IMG_AW-1:0] in_read_address,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_status,
  output logic [TRK_W-1:0]       out_cur_track,
  output logic [SEC_W-1:0]       out_cur_sector,
  output logic [7:0]             out_fill_position,
  output logic [7:0]             out_read_data,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_regs_t         cfg;
  nav_res_t          nav;
  logic [TRK_W-1:0]  cur_trk;
  logic [SEC_W-1:0]  cur_sec;
  logic              ram_we;
  logic [IMG_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [IMG_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // configuration registers
  dscw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // next sector of the chain
  dscw_nav u_nav (
    .trk (cur_trk),
    .sec (cur_sec),
    .cfg (cfg),
    .nav (nav)
  );

  // request sequencer
  dscw_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_data_byte      (in_data_byte),
    .in_read_address   (in_read_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_cur_track     (out_cur_track),
    .out_cur_sector    (out_cur_sector),
    .out_fill_position (out_fill_position),
    .out_read_data     (out_read_data),
    .cur_trk           (cur_trk),
    .cur_sec           (cur_sec),
    .nav               (nav),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata)
  );

  // disk image memory
  dscw_ram #(
    .WIDTH (8),
    .DEPTH (IMAGE_BYTES)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // checks
  `DSCW_ASSERT_NEVER(a_no_same_entry, ram_we && ram_re && (ram_waddr == ram_raddr), "read and write hit the same image byte")
  `DSCW_ASSERT_IMPLY(a_full_reads_zero, out_valid && out_status, out_read_data == 8'd0, "disk full result carries read data")
  `DSCW_ASSERT_IMPLY(a_pos_range, out_valid, (out_cur_track >= 6'd1) && (out_cur_track <= 6'd42) && (out_cur_sector <= 5'd20), "write position out of range")
  `DSCW_ASSERT_NEXT(a_buf_full, in_valid && !in_stall, in_stall, "request buffer not held after accept")

endmodule

`default_nettype wire
